// ===== hw/rtl/sst_pkg.sv =====
// Shared types and constants for the sparse-set handle table.
// Used by every module of the block but sst_ram; depends on nothing.
package sst_pkg;

    // Table geometry
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int HALF_W   = 32;
    localparam int HANDLE_W = 2 * HALF_W;
    localparam int MASK_W   = 8;
    localparam logic [HALF_W-1:0] TAG_RESET = HALF_W'(1);

    // Command codes
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_e_t;

    // Request payload
    typedef struct packed {
        cmd_e_t              command;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   level_mask;
    } req_t;

    // Result payload
    typedef struct packed {
        status_e_t           status;
        logic [HANDLE_W-1:0] new_handle;
        logic [MASK_W-1:0]   found_mask;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture a new request
        logic rd_add;    // read parked index at slot live_count
        logic rd_its;    // read sparse store at the request index
        logic rd_slot;   // read dense stores at the mapped slot
        logic rd_last;   // read dense stores at the last live slot
        logic wr_add;    // write a new entry
        logic wr_move;   // move last entry into the freed slot
        logic wr_park;   // park freed index past the live count
        logic clear;     // drop all entries
        logic finish;    // register the result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_e_t command;
        logic   full;
        logic   pre_ok;
        logic   found;
    } dp_stat_t;

endpackage

// ===== hw/rtl/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sst_ctrl.sv =====
// Command sequencer for the sparse-set handle table.
// Depends on sst_pkg; drives sst_dp through dp_cmd_t.
module sst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sst_pkg::dp_stat_t stat,
    output sst_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import sst_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ISSUE = 7'b0000010,
        S_ADD   = 7'b0000100,
        S_SLOT  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_MOVE  = 7'b0100000,
        S_PARK  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                case (stat.command)
                    CMD_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_add = 1'b1;
                            state_next = S_ADD;
                        end
                    end
                    default:
                    begin
                        if (stat.pre_ok)
                        begin
                            cmd.rd_its = 1'b1;
                            state_next = S_SLOT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_ADD:
            begin
                cmd.wr_add = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_SLOT:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.found && stat.command == CMD_DELETE)
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = S_MOVE;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MOVE:
            begin
                cmd.wr_move = 1'b1;
                state_next  = S_PARK;
            end
            S_PARK:
            begin
                cmd.wr_park = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== hw/rtl/sst_dp.sv =====
// Datapath of the sparse-set handle table: counters, tag, stores, result.
// Depends on sst_pkg and sst_ram; steered by sst_ctrl.
module sst_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sst_pkg::req_t              req,
    input  logic                       cfg_we,
    input  logic [sst_pkg::HALF_W-1:0] cfg_data,
    input  sst_pkg::dp_cmd_t           cmd,
    output sst_pkg::dp_stat_t          stat,
    output sst_pkg::rsp_t              rsp
);
    import sst_pkg::*;

    // Control state
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W-1:0]  issued_reg, issued_next;
    logic [HALF_W-1:0] tag_reg;

    // Request and work registers
    cmd_e_t              command_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [IDX_W-1:0]    slot_reg;
    rsp_t                rsp_reg, rsp_next;

    // Store ports
    logic              hidx_we, hidx_re, mask_we, mask_re, its_we, its_re;
    logic [IDX_W-1:0]  hidx_waddr, hidx_raddr, hidx_wdata, hidx_rdata;
    logic [IDX_W-1:0]  mask_waddr, mask_raddr;
    logic [MASK_W-1:0] mask_wdata, mask_rdata;
    logic [IDX_W-1:0]  its_waddr, its_raddr, its_wdata, its_rdata;

    // Derived values
    logic [HALF_W-1:0] low, low_m1;
    logic [IDX_W-1:0]  req_idx, last_slot, add_idx, live_slot;
    logic [CNT_W-1:0]  live_m1;
    logic              reuse, full, pre_ok, found;

    assign low       = handle_reg[HALF_W-1:0];
    assign low_m1    = low - HALF_W'(1);
    assign req_idx   = low_m1[IDX_W-1:0];
    assign live_m1   = live_reg - CNT_W'(1);
    assign last_slot = live_m1[IDX_W-1:0];
    assign live_slot = live_reg[IDX_W-1:0];
    assign reuse     = (live_reg < issued_reg);
    assign full      = (live_reg >= CNT_W'(CAPACITY));
    assign add_idx   = reuse ? hidx_rdata : issued_reg[IDX_W-1:0];

    // Handle checks: tag, nonzero low half, index issued, then both-way map
    assign pre_ok = (handle_reg[HANDLE_W-1:HALF_W] == tag_reg) && (low != '0)
                    && (low_m1 < HALF_W'(issued_reg));
    assign found  = pre_ok && ({1'b0, slot_reg} < live_reg) && (hidx_rdata == req_idx);

    assign stat.command = command_reg;
    assign stat.full    = full;
    assign stat.pre_ok  = pre_ok;
    assign stat.found   = found;

    // Dense store: handle index per slot
    always_comb
    begin
        hidx_re    = cmd.rd_add | cmd.rd_slot | cmd.rd_last;
        hidx_raddr = live_slot;
        if (cmd.rd_slot)
        begin
            hidx_raddr = its_rdata;
        end
        else if (cmd.rd_last)
        begin
            hidx_raddr = last_slot;
        end
        hidx_we    = cmd.wr_add | cmd.wr_move | cmd.wr_park;
        hidx_waddr = live_slot;
        hidx_wdata = add_idx;
        if (cmd.wr_move)
        begin
            hidx_waddr = slot_reg;
            hidx_wdata = hidx_rdata;
        end
        else if (cmd.wr_park)
        begin
            hidx_waddr = last_slot;
            hidx_wdata = req_idx;
        end
    end

    // Dense store: severity mask per slot
    always_comb
    begin
        mask_re    = cmd.rd_slot | cmd.rd_last;
        mask_raddr = cmd.rd_slot ? its_rdata : last_slot;
        mask_we    = cmd.wr_add | cmd.wr_move;
        mask_waddr = cmd.wr_move ? slot_reg : live_slot;
        mask_wdata = cmd.wr_move ? mask_rdata : mask_reg;
    end

    // Sparse store: slot per handle index
    always_comb
    begin
        its_re    = cmd.rd_its;
        its_raddr = req_idx;
        its_we    = cmd.wr_add | cmd.wr_move | cmd.wr_park;
        its_waddr = add_idx;
        its_wdata = live_slot;
        if (cmd.wr_move)
        begin
            its_waddr = hidx_rdata;
            its_wdata = slot_reg;
        end
        else if (cmd.wr_park)
        begin
            its_waddr = req_idx;
            its_wdata = last_slot;
        end
    end

    sst_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_hidx_ram (
        .clk   (clk),
        .we    (hidx_we),
        .waddr (hidx_waddr),
        .wdata (hidx_wdata),
        .re    (hidx_re),
        .raddr (hidx_raddr),
        .rdata (hidx_rdata)
    );

    sst_ram #(.WIDTH(MASK_W), .DEPTH(CAPACITY)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    sst_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_its_ram (
        .clk   (clk),
        .we    (its_we),
        .waddr (its_waddr),
        .wdata (its_wdata),
        .re    (its_re),
        .raddr (its_raddr),
        .rdata (its_rdata)
    );

    // Counter updates
    always_comb
    begin
        live_next   = live_reg;
        issued_next = issued_reg;
        if (cmd.clear)
        begin
            live_next   = '0;
            issued_next = '0;
        end
        else if (cmd.wr_add)
        begin
            live_next = live_reg + CNT_W'(1);
            if (!reuse)
            begin
                issued_next = issued_reg + CNT_W'(1);
            end
        end
        else if (cmd.wr_park)
        begin
            live_next = live_m1;
        end
    end

    // Result selection
    always_comb
    begin
        rsp_next = '0;
        case (command_reg)
            CMD_ADD:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.new_handle = {tag_reg, HALF_W'(add_idx) + HALF_W'(1)};
                end
            end
            CMD_FIND:
            begin
                if (found)
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.found_mask = mask_rdata;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            CMD_DELETE:
            begin
                rsp_next.status = cmd.wr_park ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            issued_reg <= '0;
            tag_reg    <= TAG_RESET;
        end
        else
        begin
            live_reg   <= live_next;
            issued_reg <= issued_next;
            if (cfg_we)
            begin
                tag_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= req.command;
            handle_reg  <= req.handle;
            mask_reg    <= req.level_mask;
        end
        if (cmd.rd_slot)
        begin
            slot_reg <= its_rdata;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hw/rtl/sparse_set_handle_table_unit.sv =====
// Top level of the sparse-set handle table.
// Depends on sst_pkg, sst_ctrl, sst_dp (and sst_ram through sst_dp).
//
// Usage:
//   Request channel: present req with start high; it is taken at an edge
//   where start is high and busy is low. Commands are add, find, delete and
//   clear all. One request is worked on at a time.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot stall it and must take it in that cycle.
//   Configuration: cfg_data (handle tag) is written at an edge where
//   cfg_valid and cfg_ready are high; cfg_ready is high while idle.
//   Steps to done: clear, a full add and a handle failing the tag/index
//   check end at issue; add reads the parked index, then writes; find and
//   delete read the sparse store, then the dense stores, then check the map;
//   a found delete reads the last entry, moves it and parks the freed index.
//   A new request may be taken in the done cycle. The steps follow the chain
//   of registered-read store reads and a delete's two writes per index store.
//   Reset: live and issued counts clear, tag returns to 1. The stores are
//   not cleared; every read of them is validated against the counts.
module sparse_set_handle_table_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sst_pkg::req_t              req,
    output logic                       done,
    output sst_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sst_pkg::HALF_W-1:0] cfg_data
);
    import sst_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = ~busy;

    sst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sst_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp)
    );

    // An accepted request always makes the block busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Results are never back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

    // A failed request carries no handle and no mask
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.new_handle == '0 && rsp.found_mask == '0))
        else $error("failed result carries data");

    // No result while idle unless the previous cycle finished a request
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in progress");

endmodule

// ===== verif/sparse_set_handle_table_unit_tb.sv =====
// Self-checking testbench for sparse_set_handle_table_unit: directed and random
// add/find/delete/clear requests with handle tag rewrites, checked against a local table model.
// Depends on sst_pkg and the RTL of the block only.
module sparse_set_handle_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BACKLOG_MAX = 4;

    // One entry of the stimulus backlog: a request or a tag write
    typedef struct {
        logic              is_tag_write;
        req_t              rq;
        logic [HALF_W-1:0] tag;
    } backlog_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    req_t              req = '0;
    logic              done;
    rsp_t              rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [HALF_W-1:0] cfg_data = '0;

    // Model of the table
    logic [HALF_W-1:0] tag_q = TAG_RESET;
    logic [IDX_W-1:0]  slot_hidx [CAPACITY];
    logic [MASK_W-1:0] slot_mask [CAPACITY];
    logic [IDX_W-1:0]  index_slot [CAPACITY];
    logic [CNT_W-1:0]  live_n = '0;
    logic [CNT_W-1:0]  issued_n = '0;

    // Stimulus and checking state
    backlog_t          cmd_backlog [$];
    backlog_t          cur;
    rsp_t              outcomes_due [$];
    rsp_t              want;
    logic [HANDLE_W-1:0] issued_handles [$];
    logic [HALF_W-1:0] gen_tag = TAG_RESET;
    logic              drv_active = 1'b0;
    logic              req_taken = 1'b0;
    logic              tag_taken = 1'b0;
    int                idle_left = 0;
    int                burst_left = 0;
    int                fail_count = 0;
    int                cycles = 0;

    sparse_set_handle_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached, %0d results outstanding", $time,
                     outcomes_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Handle lookup, validated through the index and back through the slot
    function automatic logic locate(input logic [HANDLE_W-1:0] h, output logic [IDX_W-1:0] slot);
        logic [HALF_W-1:0] low;
        logic [HALF_W-1:0] idx;
        low  = h[HALF_W-1:0];
        slot = '0;
        if (h[HANDLE_W-1:HALF_W] != tag_q || low == '0)
            return 1'b0;
        idx = low - HALF_W'(1);
        if (idx >= HALF_W'(issued_n))
            return 1'b0;
        slot = index_slot[idx[IDX_W-1:0]];
        if (CNT_W'(slot) >= live_n)
            return 1'b0;
        return slot_hidx[slot] == idx[IDX_W-1:0];
    endfunction

    // Applies one request to the model and returns its result
    function automatic rsp_t table_outcome(input req_t r);
        rsp_t              o;
        logic [IDX_W-1:0]  slot;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  last;
        logic [IDX_W-1:0]  del_idx;
        logic [IDX_W-1:0]  last_idx;
        o = '0;
        o.status = ST_OK;
        case (r.command)
            CMD_ADD:
            begin
                if (live_n == CNT_W'(CAPACITY))
                    o.status = ST_FULL;
                else
                begin
                    slot = live_n[IDX_W-1:0];
                    // reuse a parked index before issuing a fresh one
                    if (live_n < issued_n)
                        idx = slot_hidx[slot];
                    else
                    begin
                        idx = issued_n[IDX_W-1:0];
                        issued_n++;
                    end
                    slot_hidx[slot] = idx;
                    slot_mask[slot] = r.level_mask;
                    index_slot[idx] = slot;
                    live_n++;
                    o.new_handle = {tag_q, HALF_W'(idx) + HALF_W'(1)};
                    issued_handles.push_back(o.new_handle);
                    if (issued_handles.size() > 320)
                        void'(issued_handles.pop_front());
                end
            end
            CMD_FIND:
            begin
                if (locate(r.handle, slot))
                    o.found_mask = slot_mask[slot];
                else
                    o.status = ST_NOT_FOUND;
            end
            CMD_DELETE:
            begin
                if (locate(r.handle, slot))
                begin
                    // last live entry fills the hole, freed index parks past it
                    last     = IDX_W'(live_n - 1);
                    del_idx  = slot_hidx[slot];
                    last_idx = slot_hidx[last];
                    slot_hidx[slot]      = last_idx;
                    slot_mask[slot]      = slot_mask[last];
                    index_slot[last_idx] = slot;
                    slot_hidx[last]      = del_idx;
                    index_slot[del_idx]  = last;
                    live_n = CNT_W'(last);
                    for (int i = issued_handles.size() - 1; i >= 0; i--)
                        if (issued_handles[i] == r.handle)
                            issued_handles.delete(i);
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            default:
            begin
                live_n   = '0;
                issued_n = '0;
            end
        endcase
        return o;
    endfunction

    // Idle cycles between requests: mostly none or short, some long, bursts of none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 3)
        begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Driver: presents backlog entries at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (drv_active && (req_taken || tag_taken))
            begin
                drv_active = 1'b0;
                idle_left  = pick_gap();
            end
            if (!drv_active)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].is_tag_write || outcomes_due.size() == 0))
                begin
                    // tag writes wait until every result is back
                    cur = cmd_backlog.pop_front();
                    drv_active = 1'b1;
                    req      <= cur.rq;
                    cfg_data <= cur.tag;
                end
            end
            start     <= drv_active && !cur.is_tag_write;
            cfg_valid <= drv_active && cur.is_tag_write;
        end
    end

    // Monitor: checks results and records accepted requests at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: result with none pending, got status %0d handle %h mask %h",
                             $time, rsp.status, rsp.new_handle, rsp.found_mask);
                    fail_count++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.new_handle !== want.new_handle)
                    begin
                        $display("%0t: new_handle expected %h, got %h", $time,
                                 want.new_handle, rsp.new_handle);
                        fail_count++;
                    end
                    if (rsp.found_mask !== want.found_mask)
                    begin
                        $display("%0t: found_mask expected %h, got %h", $time,
                                 want.found_mask, rsp.found_mask);
                        fail_count++;
                    end
                end
            end
            req_taken = start && !busy;
            tag_taken = cfg_valid && cfg_ready;
            if (req_taken)
                outcomes_due.push_back(table_outcome(req));
            if (tag_taken)
                tag_q = cfg_data;
        end
    end

    // Handle choice for find and delete: mostly issued handles, the rest guessed or malformed
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        logic [HANDLE_W-1:0] h;
        r = $urandom_range(99);
        if (r < 70 && issued_handles.size() != 0)
            h = issued_handles[$urandom_range(issued_handles.size() - 1)];
        else if (r < 78)
            h = {gen_tag, HALF_W'($urandom_range(CAPACITY, 1))};
        else if (r < 83)
            h = {gen_tag, HALF_W'(0)};
        else if (r < 88)
            h = {gen_tag, HALF_W'($urandom)};
        else if (r < 94)
            h = {gen_tag ^ (HALF_W'(1) << $urandom_range(HALF_W - 1)),
                 HALF_W'($urandom_range(CAPACITY, 1))};
        else
            h = {$urandom, $urandom};
        return h;
    endfunction

    task automatic send(input cmd_e_t c, input logic [HANDLE_W-1:0] h,
                        input logic [MASK_W-1:0] m);
        backlog_t b;
        b.is_tag_write  = 1'b0;
        b.rq.command    = c;
        b.rq.handle     = h;
        b.rq.level_mask = m;
        b.tag           = '0;
        while (cmd_backlog.size() >= BACKLOG_MAX)
            @(posedge clk);
        cmd_backlog.push_back(b);
    endtask

    task automatic write_tag(input logic [HALF_W-1:0] t);
        backlog_t b;
        b.is_tag_write = 1'b1;
        b.rq           = '0;
        b.tag          = t;
        gen_tag        = t;
        while (cmd_backlog.size() >= BACKLOG_MAX)
            @(posedge clk);
        cmd_backlog.push_back(b);
    endtask

    // Random requests; weights in thousandths, clear takes the remainder
    task automatic run_phase(input int n, input int w_add, input int w_find, input int w_del);
        int     r;
        cmd_e_t c;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(999);
            if (r < w_add)
                c = CMD_ADD;
            else if (r < w_add + w_find)
                c = CMD_FIND;
            else if (r < w_add + w_find + w_del)
                c = CMD_DELETE;
            else
                c = CMD_CLEAR;
            send(c, pick_handle(), MASK_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty table, then three adds, two with extreme masks
        send(CMD_FIND,   {32'd1, 32'd1}, 8'h00);
        send(CMD_DELETE, {32'd1, 32'd1}, 8'hFF);
        send(CMD_ADD,    '1, 8'h00);
        send(CMD_ADD,    '0, 8'hFF);
        send(CMD_ADD,    64'h5555_5555_AAAA_AAAA, 8'hA5);
        send(CMD_FIND,   {32'd1, 32'd1}, 8'h00);
        send(CMD_FIND,   {32'd1, 32'd2}, 8'h00);
        // low bits zero, wrong tag, index not issued, huge index, all ones
        send(CMD_FIND,   {32'd1, 32'd0}, 8'h00);
        send(CMD_FIND,   {32'd2, 32'd1}, 8'h00);
        send(CMD_FIND,   {32'd1, 32'd4}, 8'h00);
        send(CMD_FIND,   {32'd1, 32'hFFFF_FFFF}, 8'h00);
        send(CMD_FIND,   '1, 8'hFF);
        // delete moves the last entry, then the parked index is reused
        send(CMD_DELETE, {32'd1, 32'd1}, 8'h00);
        send(CMD_FIND,   {32'd1, 32'd1}, 8'h00);
        send(CMD_FIND,   {32'd1, 32'd3}, 8'h00);
        send(CMD_DELETE, {32'd1, 32'd1}, 8'h00);
        send(CMD_ADD,    '0, 8'h3C);
        send(CMD_FIND,   {32'd1, 32'd1}, 8'h00);
        send(CMD_CLEAR,  '1, 8'hFF);
        send(CMD_FIND,   {32'd1, 32'd2}, 8'h00);
        send(CMD_ADD,    '0, 8'h81);
        // old handles die when the tag changes
        write_tag('1);
        send(CMD_FIND,   {32'd1, 32'd1}, 8'h00);
        send(CMD_ADD,    '0, 8'h5A);
        send(CMD_FIND,   {32'hFFFF_FFFF, 32'd2}, 8'h00);
        write_tag('0);
        send(CMD_ADD,    '0, 8'h42);
        send(CMD_FIND,   {32'd0, 32'd3}, 8'h00);

        // random phases: mixed, fill to full, churn near full, other tags
        write_tag(TAG_RESET);
        run_phase(300, 400, 350, 240);
        write_tag($urandom);
        send(CMD_CLEAR, '0, '0);
        run_phase(350, 800, 150, 50);
        run_phase(250, 300, 350, 350);
        write_tag('1);
        run_phase(150, 450, 300, 200);
        write_tag('0);
        run_phase(150, 400, 300, 280);

        // drain, then let the block settle
        while (cmd_backlog.size() != 0 || drv_active || outcomes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outcomes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
